// File: rtl/core/bmpr_pkg.sv
package bmpr_pkg;

  // palette geometry
  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned PalAddrW       = 8;
  localparam int unsigned ColourW        = 24;

  // saturation limit of the column and row counters
  localparam logic [14:0] PosMax = 15'h7fff;

  // item modes on the input channel
  typedef enum logic [1:0] {
    MODE_PAL   = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_START = 2'd2
  } mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_BOTTOM_UP = 2'd2
  } reg_idx_e;

  // escape codes following a zero count
  localparam logic [7:0] EscEol   = 8'd0;
  localparam logic [7:0] EscEnd   = 8'd1;
  localparam logic [7:0] EscDelta = 8'd2;

  // result kinds
  localparam logic KindSpan = 1'b0;
  localparam logic KindDone = 1'b1;

  // parser phases, one-hot
  typedef enum logic [5:0] {
    PH_COUNT = 6'b000001,
    PH_VALUE = 6'b000010,
    PH_DX    = 6'b000100,
    PH_DY    = 6'b001000,
    PH_LIT   = 6'b010000,
    PH_PAD   = 6'b100000
  } phase_e;

  // parser result handed to the output stage
  typedef struct packed {
    logic        emit;
    logic        kind;
    logic [13:0] dest_row;
    logic [13:0] start_col;
    logic [7:0]  span_length;
  } res_t;

endpackage

// File: rtl/core/bmpr_in_if.sv
interface bmpr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic [7:0] palette_index;
  logic [7:0] pal_red;
  logic [7:0] pal_green;
  logic [7:0] pal_blue;

  modport source (
    output valid, mode, data_byte, palette_index, pal_red, pal_green, pal_blue,
    input  ready
  );
  modport sink (
    input  valid, mode, data_byte, palette_index, pal_red, pal_green, pal_blue,
    output ready
  );
endinterface

// File: rtl/core/bmpr_out_if.sv
interface bmpr_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [13:0] dest_row;
  logic [13:0] start_col;
  logic [7:0]  span_length;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (
    output valid, out_kind, dest_row, start_col, span_length, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, out_kind, dest_row, start_col, span_length, red, green, blue,
    output ready
  );
endinterface

// File: rtl/core/bmp_rle8_palette_decoder.sv
// BMP RLE8 decoder with a 256-entry palette.
// Input channel in_i: each transaction is a palette write (mode 0), a
// compressed stream byte (mode 1) or a start of a new image (mode 2).
// Output channel out_o: pixel spans (row, start column, clipped length,
// palette colour) and at most one image-finished marker per image.
// Configuration over the APB port: width at 0x0, height at 0x4, bottom-up
// flag at 0x8, written by the user only while the block is idle; not enforced.
// Throughput: one input transaction per cycle, sustained, when the
// receiver takes results as they come.
// Path: the accepting edge loads stage 1 and the palette read; stage 1 then
// moves into the output register, which holds the result until the receiver
// takes it.
// The receiver may stall at will: a result waits in stage 1 and in the
// output register, and input ready drops only when both are full.
// Reset clears the parser, sets width and height to one and bottom-up to
// one; palette contents are undefined until written and need no clearing.
module bmp_rle8_palette_decoder #(
  parameter int unsigned MAX_DIM = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmpr_in_if.sink     in_i,
  bmpr_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [14:0] width_q, height_q;
  logic        bottom_up_q;
  logic        cfg_we;
  logic        acc;
  logic        in_ready;
  logic        s1_hold;
  logic [bmpr_pkg::ColourW-1:0] rdata;
  bmpr_pkg::res_t res;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 15'd1;
      height_q    <= 15'd1;
      bottom_up_q <= 1'b1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        bmpr_pkg::REG_WIDTH:     width_q     <= pwdata[14:0];
        bmpr_pkg::REG_HEIGHT:    height_q    <= pwdata[14:0];
        bmpr_pkg::REG_BOTTOM_UP: bottom_up_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bmpr_pkg::REG_WIDTH:     prdata = {17'd0, width_q};
      bmpr_pkg::REG_HEIGHT:    prdata = {17'd0, height_q};
      bmpr_pkg::REG_BOTTOM_UP: prdata = {31'd0, bottom_up_q};
      default:                 prdata = '0;
    endcase
  end

  // input handshake
  assign in_i.ready = in_ready;
  assign acc        = in_i.valid && in_ready;

  bmpr_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .mode_i      (in_i.mode),
    .byte_i      (in_i.data_byte),
    .width_i     (width_q),
    .height_i    (height_q),
    .bottom_up_i (bottom_up_q),
    .res_o       (res)
  );

  // palette: written by palette transactions, read with the span's byte
  bmpr_pal_mem u_pal_mem (
    .clk_i   (clk_i),
    .we_i    (acc && in_i.mode == bmpr_pkg::MODE_PAL),
    .waddr_i (in_i.palette_index),
    .wdata_i ({in_i.pal_red, in_i.pal_green, in_i.pal_blue}),
    .re_i    (acc && res.emit && res.kind == bmpr_pkg::KindSpan),
    .raddr_i (in_i.data_byte),
    .rdata_o (rdata)
  );

  bmpr_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .res_i      (res),
    .colour_i   (rdata),
    .in_ready_o (in_ready),
    .s1_hold_o  (s1_hold),
    .out_o      (out_o)
  );

  // the palette read data must survive a stalled stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_hold |=> $stable(rdata))
    else $error("palette read data lost during stall");

endmodule

// File: rtl/core/bmpr_pal_mem.sv
module bmpr_pal_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [bmpr_pkg::PalAddrW-1:0] waddr_i,
  input  logic [bmpr_pkg::ColourW-1:0]  wdata_i,
  input  logic                          re_i,
  input  logic [bmpr_pkg::PalAddrW-1:0] raddr_i,
  output logic [bmpr_pkg::ColourW-1:0]  rdata_o
);

  logic [bmpr_pkg::ColourW-1:0] mem_q [bmpr_pkg::PaletteEntries];
  logic [bmpr_pkg::ColourW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bmpr_parser.sv
module bmpr_parser #(
  parameter int unsigned MAX_DIM = 16384
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [1:0]     mode_i,
  input  logic [7:0]     byte_i,
  input  logic [14:0]    width_i,
  input  logic [14:0]    height_i,
  input  logic           bottom_up_i,
  output bmpr_pkg::res_t res_o
);

  localparam logic [14:0] DimMax = 15'(MAX_DIM);

  bmpr_pkg::phase_e phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic [14:0] col_q, col_d;
  logic [14:0] row_q, row_d;
  logic [7:0]  lit_q, lit_d;
  logic        pad_q, pad_d;
  logic        fin_q, fin_d;

  logic [14:0] w_eff, h_eff;
  logic [14:0] rem;
  logic [7:0]  run_len;
  logic [15:0] col_sum, row_sum1, row_sumb;
  logic [14:0] col_sat, row_sat1, row_satb;
  logic [14:0] flip_row;
  logic [7:0]  lit_dec;
  logic        col_in;

  // clamp the size registers
  assign w_eff = (width_i > DimMax) ? DimMax : width_i;
  assign h_eff = (height_i > DimMax) ? DimMax : height_i;

  // run clipping against the width
  assign col_in  = col_q < w_eff;
  assign rem     = w_eff - col_q;
  assign run_len = (rem > {7'd0, held_q}) ? held_q : rem[7:0];

  // saturating position updates
  assign col_sum  = {1'b0, col_q} + {8'd0, byte_i};
  assign col_sat  = col_sum[15] ? bmpr_pkg::PosMax : col_sum[14:0];
  assign row_sum1 = {1'b0, row_q} + 16'd1;
  assign row_sat1 = row_sum1[15] ? bmpr_pkg::PosMax : row_sum1[14:0];
  assign row_sumb = {1'b0, row_q} + {8'd0, byte_i};
  assign row_satb = row_sumb[15] ? bmpr_pkg::PosMax : row_sumb[14:0];

  // vertical flip
  assign flip_row = bottom_up_i ? (h_eff - 15'd1 - row_q) : row_q;
  assign lit_dec  = lit_q - 8'd1;

  // next state and result for one transaction
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    col_d   = col_q;
    row_d   = row_q;
    lit_d   = lit_q;
    pad_d   = pad_q;
    fin_d   = fin_q;
    res_o   = '0;
    res_o.dest_row  = flip_row[13:0];
    res_o.start_col = col_q[13:0];
    if (mode_i == bmpr_pkg::MODE_START) begin
      phase_d = bmpr_pkg::PH_COUNT;
      held_d  = '0;
      col_d   = '0;
      row_d   = '0;
      lit_d   = '0;
      pad_d   = 1'b0;
      fin_d   = 1'b0;
    end else if (mode_i == bmpr_pkg::MODE_DATA && !fin_q) begin
      if (row_q >= h_eff) begin
        fin_d      = 1'b1;
        res_o      = '0;
        res_o.emit = 1'b1;
        res_o.kind = bmpr_pkg::KindDone;
      end else begin
        case (phase_q)
          bmpr_pkg::PH_COUNT: begin
            held_d  = byte_i;
            phase_d = bmpr_pkg::PH_VALUE;
          end
          bmpr_pkg::PH_VALUE: begin
            phase_d = bmpr_pkg::PH_COUNT;
            if (held_q != 8'd0) begin
              if (col_in) begin
                res_o.emit        = 1'b1;
                res_o.kind        = bmpr_pkg::KindSpan;
                res_o.span_length = run_len;
                col_d             = col_q + {7'd0, run_len};
              end
            end else if (byte_i == bmpr_pkg::EscEol) begin
              col_d = '0;
              row_d = row_sat1;
              if (row_sat1 >= h_eff) begin
                fin_d      = 1'b1;
                res_o      = '0;
                res_o.emit = 1'b1;
                res_o.kind = bmpr_pkg::KindDone;
              end
            end else if (byte_i == bmpr_pkg::EscEnd) begin
              fin_d      = 1'b1;
              res_o      = '0;
              res_o.emit = 1'b1;
              res_o.kind = bmpr_pkg::KindDone;
            end else if (byte_i == bmpr_pkg::EscDelta) begin
              phase_d = bmpr_pkg::PH_DX;
            end else begin
              lit_d   = byte_i;
              pad_d   = byte_i[0];
              phase_d = bmpr_pkg::PH_LIT;
            end
          end
          bmpr_pkg::PH_DX: begin
            col_d   = col_sat;
            phase_d = bmpr_pkg::PH_DY;
          end
          bmpr_pkg::PH_DY: begin
            row_d   = row_satb;
            phase_d = bmpr_pkg::PH_COUNT;
            if (row_satb >= h_eff) begin
              fin_d      = 1'b1;
              res_o      = '0;
              res_o.emit = 1'b1;
              res_o.kind = bmpr_pkg::KindDone;
            end
          end
          bmpr_pkg::PH_LIT: begin
            if (col_in) begin
              res_o.emit        = 1'b1;
              res_o.kind        = bmpr_pkg::KindSpan;
              res_o.span_length = 8'd1;
              col_d             = col_q + 15'd1;
            end
            lit_d = lit_dec;
            if (lit_dec == 8'd0) begin
              phase_d = pad_q ? bmpr_pkg::PH_PAD : bmpr_pkg::PH_COUNT;
              pad_d   = 1'b0;
            end
          end
          default: begin
            pad_d   = 1'b0;
            phase_d = bmpr_pkg::PH_COUNT;
          end
        endcase
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bmpr_pkg::PH_COUNT;
      held_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      lit_q   <= '0;
      pad_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      col_q   <= col_d;
      row_q   <= row_d;
      lit_q   <= lit_d;
      pad_q   <= pad_d;
      fin_q   <= fin_d;
    end
  end

  // a span is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && res_o.emit && res_o.kind == bmpr_pkg::KindSpan |-> res_o.span_length != 8'd0)
    else $error("empty span produced");

  // a span never leaves the clamped width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && res_o.emit && res_o.kind == bmpr_pkg::KindSpan
      |=> col_q <= w_eff && col_q != 15'd0)
    else $error("span ran past the image width");

  // nothing leaves a finished image until a new start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q && acc_i && mode_i != bmpr_pkg::MODE_START |-> !res_o.emit && fin_d)
    else $error("result produced after image finished");

endmodule

// File: rtl/core/bmpr_out_buf.sv
module bmpr_out_buf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  bmpr_pkg::res_t               res_i,
  input  logic [bmpr_pkg::ColourW-1:0] colour_i,
  output logic                         in_ready_o,
  output logic                         s1_hold_o,
  bmpr_out_if.source                   out_o
);

  logic       s1_valid_q, s1_valid_d;
  bmpr_pkg::res_t s1_q;
  logic       out_valid_q, out_valid_d;
  logic       kind_q;
  logic [13:0] row_q, col_q;
  logic [7:0]  len_q;
  logic [bmpr_pkg::ColourW-1:0] colour_q;
  logic       s1_adv;

  // stage 1 waits for the palette read, then moves into the output register
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign s1_hold_o  = s1_valid_q && !s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc_i && res_i.emit) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (acc_i && res_i.emit) begin
      s1_q <= res_i;
    end
    if (s1_adv) begin
      kind_q   <= s1_q.kind;
      row_q    <= s1_q.dest_row;
      col_q    <= s1_q.start_col;
      len_q    <= s1_q.span_length;
      colour_q <= (s1_q.kind == bmpr_pkg::KindDone) ? '0 : colour_i;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_kind    = kind_q;
  assign out_o.dest_row    = row_q;
  assign out_o.start_col   = col_q;
  assign out_o.span_length = len_q;
  assign out_o.red         = colour_q[23:16];
  assign out_o.green       = colour_q[15:8];
  assign out_o.blue        = colour_q[7:0];

endmodule

// File: tb/sv/bmp_rle8_palette_decoder_tb.sv
`timescale 1ns / 1ps

module bmp_rle8_palette_decoder_tb;

  localparam int unsigned DimLimit   = 16384;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleGap  = 8;
  localparam logic [1:0]  ModeUnused = 2'd3;

  // one input transaction and one result transaction
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [13:0] dest_row;
    logic [13:0] start_col;
    logic [7:0]  span_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } span_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_TYPED
  } chk_e;

  typedef struct packed {
    item_t it;
    chk_e  chk;
    span_t exp;
  } drow_t;

  localparam span_t NoSpan    = '0;
  localparam span_t ImageDone =
    '{bmpr_pkg::KindDone, 14'd0, 14'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bmpr_in_if  in_if ();
  bmpr_out_if out_if ();

  bmp_rle8_palette_decoder #(
    .MAX_DIM(DimLimit)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // decoder state as predicted
  logic [23:0]       palette [bmpr_pkg::PaletteEntries];
  bit                pal_loaded [bmpr_pkg::PaletteEntries];
  logic [7:0]        loaded_q [$];
  bmpr_pkg::phase_e  phase;
  int unsigned       held_count;
  int unsigned       column;
  int unsigned       row_pos;
  int unsigned       literals_left;
  bit                pad_pending;
  bit                finished;
  int unsigned       cfg_width;
  int unsigned       cfg_height;
  bit                cfg_bottom_up;

  span_t        spans_due [$];
  int unsigned  errors;
  int unsigned  items_sent;
  int unsigned  spans_checked;
  int unsigned  ends_checked;
  int unsigned  hold_requests;
  int unsigned  holds_done;
  int unsigned  hold_left;
  bit           calm;

  // directed stimulus, starting from the reset configuration
  drow_t dir_tab [24] = '{
    '{'{bmpr_pkg::MODE_PAL,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_QUIET, NoSpan},
    '{'{bmpr_pkg::MODE_PAL,   8'h00, 8'hff, 8'hff, 8'hff, 8'hff}, CHK_QUIET, NoSpan},
    '{'{bmpr_pkg::MODE_PAL,   8'h00, 8'ha5, 8'h12, 8'h34, 8'h56}, CHK_QUIET, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'hff, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_QUIET, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'hff, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_TYPED,
      '{bmpr_pkg::KindSpan, 14'd0, 14'd0, 8'd1, 8'hff, 8'hff, 8'hff}},
    '{'{bmpr_pkg::MODE_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_QUIET, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  bmpr_pkg::EscEol, 8'h00, 8'h00, 8'h00, 8'h00},
      CHK_TYPED, ImageDone},
    '{'{bmpr_pkg::MODE_DATA,  8'h07, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_QUIET, NoSpan},
    '{'{ModeUnused,           8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, CHK_QUIET, NoSpan},
    '{'{bmpr_pkg::MODE_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_QUIET, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'h03, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'ha5, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_TYPED,
      '{bmpr_pkg::KindSpan, 14'd0, 14'd0, 8'd1, 8'h12, 8'h34, 8'h56}},
    '{'{bmpr_pkg::MODE_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'hff, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'hde, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  bmpr_pkg::EscEnd, 8'h00, 8'h00, 8'h00, 8'h00},
      CHK_TYPED, ImageDone},
    '{'{bmpr_pkg::MODE_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  bmpr_pkg::EscDelta, 8'h00, 8'h00, 8'h00, 8'h00},
      CHK_MODEL, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'hff, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NoSpan},
    '{'{bmpr_pkg::MODE_DATA,  8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_TYPED, ImageDone},
    '{'{bmpr_pkg::MODE_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, NoSpan}
  };

  // sizes above the limit act as the limit
  function automatic int unsigned clamp_dim(input int unsigned v);
    return (v > DimLimit) ? DimLimit : v;
  endfunction

  function automatic int unsigned sat_pos(input int unsigned a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > bmpr_pkg::PosMax) ? bmpr_pkg::PosMax : s;
  endfunction

  function automatic void clear_parser();
    phase         = bmpr_pkg::PH_COUNT;
    held_count    = 0;
    column        = 0;
    row_pos       = 0;
    literals_left = 0;
    pad_pending   = 1'b0;
    finished      = 1'b0;
  endfunction

  function automatic span_t finish_image();
    finished = 1'b1;
    return ImageDone;
  endfunction

  // span at the current position, row flipped when bottom-up
  function automatic span_t span_at(input int unsigned len, input logic [7:0] idx);
    int unsigned h;
    int unsigned r;
    span_t       s;
    h = clamp_dim(cfg_height);
    r = cfg_bottom_up ? (h - 1 - row_pos) : row_pos;
    s.kind        = bmpr_pkg::KindSpan;
    s.dest_row    = r[13:0];
    s.start_col   = column[13:0];
    s.span_length = len[7:0];
    {s.red, s.green, s.blue} = palette[idx];
    return s;
  endfunction

  // true when the next stream byte would be used as a palette index
  function automatic bit reads_colour();
    int unsigned w;
    int unsigned h;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    return !finished && row_pos < h && column < w &&
           ((phase == bmpr_pkg::PH_VALUE && held_count != 0) ||
            phase == bmpr_pkg::PH_LIT);
  endfunction

  // predicted decoder behaviour for one accepted transaction
  function automatic bit decode_item(input item_t it, output span_t res);
    int unsigned w;
    int unsigned h;
    int unsigned len;
    logic [7:0]  b;
    res = NoSpan;
    w   = clamp_dim(cfg_width);
    h   = clamp_dim(cfg_height);
    b   = it.data_byte;
    if (it.mode == bmpr_pkg::MODE_PAL) begin
      palette[it.palette_index] = {it.pal_red, it.pal_green, it.pal_blue};
      if (!pal_loaded[it.palette_index]) begin
        pal_loaded[it.palette_index] = 1'b1;
        loaded_q.push_back(it.palette_index);
      end
      return 1'b0;
    end
    if (it.mode == bmpr_pkg::MODE_START) begin
      clear_parser();
      return 1'b0;
    end
    if (it.mode != bmpr_pkg::MODE_DATA || finished) return 1'b0;
    if (row_pos >= h) begin
      res = finish_image();
      return 1'b1;
    end
    case (phase)
      bmpr_pkg::PH_COUNT: begin
        held_count = 32'(b);
        phase      = bmpr_pkg::PH_VALUE;
        return 1'b0;
      end
      bmpr_pkg::PH_VALUE: begin
        phase = bmpr_pkg::PH_COUNT;
        // encoded run, clipped at the width
        if (held_count != 0) begin
          if (column >= w) return 1'b0;
          len = w - column;
          if (len > held_count) len = held_count;
          res    = span_at(len, b);
          column = column + len;
          return 1'b1;
        end
        if (b == bmpr_pkg::EscEol) begin
          column  = 0;
          row_pos = sat_pos(row_pos, 1);
          if (row_pos >= h) begin
            res = finish_image();
            return 1'b1;
          end
          return 1'b0;
        end
        if (b == bmpr_pkg::EscEnd) begin
          res = finish_image();
          return 1'b1;
        end
        if (b == bmpr_pkg::EscDelta) begin
          phase = bmpr_pkg::PH_DX;
          return 1'b0;
        end
        // absolute run
        literals_left = 32'(b);
        pad_pending   = b[0];
        phase         = bmpr_pkg::PH_LIT;
        return 1'b0;
      end
      bmpr_pkg::PH_DX: begin
        column = sat_pos(column, 32'(b));
        phase  = bmpr_pkg::PH_DY;
        return 1'b0;
      end
      bmpr_pkg::PH_DY: begin
        row_pos = sat_pos(row_pos, 32'(b));
        phase   = bmpr_pkg::PH_COUNT;
        if (row_pos >= h) begin
          res = finish_image();
          return 1'b1;
        end
        return 1'b0;
      end
      bmpr_pkg::PH_LIT: begin
        len = 0;
        if (column < w) begin
          res    = span_at(1, b);
          column = column + 1;
          len    = 1;
        end
        literals_left = (literals_left - 1) & 32'hff;
        if (literals_left == 0) begin
          phase       = pad_pending ? bmpr_pkg::PH_PAD : bmpr_pkg::PH_COUNT;
          pad_pending = 1'b0;
        end
        return (len != 0);
      end
      default: begin
        pad_pending = 1'b0;
        phase       = bmpr_pkg::PH_COUNT;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_colour();
    return loaded_q[$urandom_range(loaded_q.size() - 1)];
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.mode          = 2'($urandom_range(3));
    it.data_byte     = 8'($urandom_range(255));
    it.palette_index = 8'($urandom_range(255));
    it.pal_red       = 8'($urandom_range(255));
    it.pal_green     = 8'($urandom_range(255));
    it.pal_blue      = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic item_t data_item(input logic [7:0] b);
    item_t it;
    it           = rand_item();
    it.mode      = bmpr_pkg::MODE_DATA;
    it.data_byte = b;
    return it;
  endfunction

  function automatic item_t start_item();
    item_t it;
    it      = rand_item();
    it.mode = bmpr_pkg::MODE_START;
    return it;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // offer one transaction, wait for it to be taken, then predict
  task automatic send_item(input item_t it, input chk_e chk, input span_t exp);
    int unsigned gap;
    span_t       res;
    bit          got;
    gap = (!calm && $urandom_range(99) < 8) ? $urandom_range(1, 5) : 0;
    // never let a stream byte read a palette entry that was not loaded
    if (it.mode == bmpr_pkg::MODE_DATA && reads_colour() && !pal_loaded[it.data_byte])
      it.data_byte = pick_colour();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.mode          <= it.mode;
    in_if.data_byte     <= it.data_byte;
    in_if.palette_index <= it.palette_index;
    in_if.pal_red       <= it.pal_red;
    in_if.pal_green     <= it.pal_green;
    in_if.pal_blue      <= it.pal_blue;
    do @(posedge clk_i); while (!in_if.ready);
    got = decode_item(it, res);
    items_sent++;
    if (chk == CHK_TYPED) spans_due.push_back(exp);
    else if (chk == CHK_MODEL && got) spans_due.push_back(res);
  endtask

  task automatic send(input item_t it);
    send_item(it, CHK_MODEL, NoSpan);
  endtask

  // drop valid in the step of the last acceptance and wait for the results
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (spans_due.size() != 0);
  endtask

  task automatic apb_write(input bmpr_pkg::reg_idx_e idx, input int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bmpr_pkg::REG_WIDTH:     cfg_width     = value & 32'h7fff;
      bmpr_pkg::REG_HEIGHT:    cfg_height    = value & 32'h7fff;
      bmpr_pkg::REG_BOTTOM_UP: cfg_bottom_up = value[0];
      default: ;
    endcase
  endtask

  // idle, then the three size and orientation registers
  task automatic configure(input int unsigned w, input int unsigned h, input bit bu);
    drain();
    repeat (SettleGap) @(posedge clk_i);
    apb_write(bmpr_pkg::REG_WIDTH, w);
    apb_write(bmpr_pkg::REG_HEIGHT, h);
    apb_write(bmpr_pkg::REG_BOTTOM_UP, 32'(bu));
  endtask

  // one random piece of stream: mostly well-formed codes, some noise
  task automatic random_segment();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (finished && $urandom_range(99) < 30) begin
      send(start_item());
    end else if (pick < 35) begin
      n = ($urandom_range(1) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 255);
      send(data_item(8'(n)));
      send(data_item(pick_colour()));
    end else if (pick < 45) begin
      send(data_item(8'h00));
      send(data_item(bmpr_pkg::EscEol));
    end else if (pick < 48) begin
      send(data_item(8'h00));
      send(data_item(bmpr_pkg::EscEnd));
    end else if (pick < 56) begin
      send(data_item(8'h00));
      send(data_item(bmpr_pkg::EscDelta));
      send(data_item(8'(($urandom_range(9) < 7) ? $urandom_range(8) : $urandom_range(255))));
      send(data_item(8'(($urandom_range(9) < 8) ? $urandom_range(2) : $urandom_range(255))));
    end else if (pick < 71) begin
      n = ($urandom_range(9) < 8) ? $urandom_range(3, 10) : $urandom_range(3, 255);
      send(data_item(8'h00));
      send(data_item(8'(n)));
      repeat (n) send(data_item(pick_colour()));
      if (n[0]) send(data_item(8'($urandom_range(255))));
    end else if (pick < 80) begin
      send_item('{bmpr_pkg::MODE_PAL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255))}, CHK_MODEL, NoSpan);
    end else if (pick < 83) begin
      send(start_item());
    end else if (pick < 84) begin
      drain();
    end else begin
      send(rand_item());
    end
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h, input bit bu,
                           input bit restart, input int unsigned count);
    int unsigned stop_at;
    configure(w, h, bu);
    if (restart) send(start_item());
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_segment();
    drain();
  endtask

  // walk the column far past the width so that it saturates, then recover
  task automatic column_walk();
    configure(DimLimit, DimLimit, 1'b0);
    send(start_item());
    repeat (130) begin
      send(data_item(8'h00));
      send(data_item(bmpr_pkg::EscDelta));
      send(data_item(8'hff));
      send(data_item(8'h00));
    end
    send(data_item(8'h04));
    send(data_item(pick_colour()));
    send(data_item(8'h00));
    send(data_item(bmpr_pkg::EscEol));
    send(data_item(8'h03));
    send(data_item(pick_colour()));
    drain();
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // receiver: random stalls, a long hold-off on request, result checking
  initial begin
    span_t e;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (spans_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual kind %0d row %0d col %0d len %0d",
                   $time, out_if.out_kind, out_if.dest_row, out_if.start_col,
                   out_if.span_length);
        end else begin
          e = spans_due.pop_front();
          if (e.kind == bmpr_pkg::KindDone) ends_checked++;
          else spans_checked++;
          check_field("out_kind", 32'(e.kind), 32'(out_if.out_kind));
          check_field("dest_row", 32'(e.dest_row), 32'(out_if.dest_row));
          check_field("start_col", 32'(e.start_col), 32'(out_if.start_col));
          check_field("span_length", 32'(e.span_length), 32'(out_if.span_length));
          check_field("red", 32'(e.red), 32'(out_if.red));
          check_field("green", 32'(e.green), 32'(out_if.green));
          check_field("blue", 32'(e.blue), 32'(out_if.blue));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HoldCycles;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  // run limit
  initial begin
    #3_000_000;
    $display("bmp_rle8_palette_decoder regression: fail");
    $finish;
  end

  // main sequence
  initial begin
    int k;
    errors        = 0;
    items_sent    = 0;
    spans_checked = 0;
    ends_checked  = 0;
    holds_done    = 0;
    hold_left     = 0;
    hold_requests <= 0;
    calm          <= 1'b0;
    for (k = 0; k < bmpr_pkg::PaletteEntries; k++) begin
      palette[k]    = '0;
      pal_loaded[k] = 1'b0;
    end
    clear_parser();
    cfg_width     = 1;
    cfg_height    = 1;
    cfg_bottom_up = 1'b1;

    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.mode          <= bmpr_pkg::MODE_PAL;
    in_if.data_byte     <= '0;
    in_if.palette_index <= '0;
    in_if.pal_red       <= '0;
    in_if.pal_green     <= '0;
    in_if.pal_blue      <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (k = 0; k < 24; k++) send_item(dir_tab[k].it, dir_tab[k].chk, dir_tab[k].exp);
    drain();

    // no stalls on either side
    calm <= 1'b1;
    run_phase(8, 4, 1'b1, 1'b1, 40);
    calm <= 1'b0;
    // receiver holds off while the sender keeps offering
    hold_requests <= hold_requests + 1;
    run_phase(DimLimit, DimLimit, 1'b0, 1'b1, 60);
    run_phase(1, 1, 1'b0, 1'b1, 30);
    run_phase(0, 3, 1'b1, 1'b1, 25);
    run_phase(5, 0, 1'b0, 1'b1, 20);
    run_phase(32767, 32767, 1'b1, 1'b1, 40);
    run_phase(13, 6, 1'b0, 1'b1, 40);
    // height lowered under an image in progress
    run_phase(13, 1, 1'b1, 1'b0, 25);
    run_phase(300, 2, 1'b1, 1'b1, 40);
    repeat (4)
      run_phase($urandom_range(1, 40), $urandom_range(1, 20), 1'($urandom_range(1)),
                $urandom_range(3) != 0, 35);
    column_walk();

    for (k = 0; k < 5000 && spans_due.size() != 0; k++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (spans_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, spans_due.size());
    end

    $display("covered %0d input transactions; checked %0d spans and %0d image ends",
             items_sent, spans_checked, ends_checked);
    $display("sizes from zero to oversize, both orientations, stalls and column saturation");
    if (errors == 0) begin
      $display("bmp_rle8_palette_decoder regression: pass");
    end else begin
      $display("bmp_rle8_palette_decoder regression: fail");
    end
    $finish;
  end

endmodule
